[rtl/core/usr_pkg.sv]
`timescale 1ns / 1ps
// usr_pkg: shared types, codes and constants for the USB standard request handler.
// No dependencies; used by all modules in rtl/core.

package usr_pkg;

	// default sizes, handed down from the top level as parameters
	localparam int DEF_MAX_ENDPOINTS  = 16;
	localparam int DEF_MAX_INTERFACES = 8;

	// configuration port
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic [2:0] REG_ENDPOINT_COUNT      = 3'd0;
	localparam logic [2:0] REG_INTERFACE_COUNT     = 3'd1;
	localparam logic [2:0] REG_CONFIGURATION_COUNT = 3'd2;
	localparam logic [2:0] REG_STRING_COUNT        = 3'd3;
	localparam logic [2:0] REG_DEVICE_STATUS_BITS  = 3'd4;

	localparam logic [4:0] RST_ENDPOINT_COUNT = 5'd1;

	// device states
	localparam logic [1:0] ST_DEFAULT    = 2'd0;
	localparam logic [1:0] ST_ADDRESS    = 2'd1;
	localparam logic [1:0] ST_CONFIGURED = 2'd2;

	// recipients
	localparam logic [4:0] RCP_DEVICE = 5'd0;
	localparam logic [4:0] RCP_IFACE  = 5'd1;
	localparam logic [4:0] RCP_EP     = 5'd2;

	// standard request codes
	localparam logic [7:0] REQ_GET_STATUS     = 8'd0;
	localparam logic [7:0] REQ_CLEAR_FEATURE  = 8'd1;
	localparam logic [7:0] REQ_SET_FEATURE    = 8'd3;
	localparam logic [7:0] REQ_SET_ADDRESS    = 8'd5;
	localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;
	localparam logic [7:0] REQ_GET_CONFIG     = 8'd8;
	localparam logic [7:0] REQ_SET_CONFIG     = 8'd9;
	localparam logic [7:0] REQ_GET_INTERFACE  = 8'd10;
	localparam logic [7:0] REQ_SET_INTERFACE  = 8'd11;

	// descriptor types in wValue high byte
	localparam logic [7:0] DT_DEVICE    = 8'd1;
	localparam logic [7:0] DT_CONFIG    = 8'd2;
	localparam logic [7:0] DT_STRING    = 8'd3;
	localparam logic [7:0] DT_QUALIFIER = 8'd6;

	// descriptor kinds reported
	localparam logic [2:0] DK_NONE      = 3'd0;
	localparam logic [2:0] DK_DEVICE    = 3'd1;
	localparam logic [2:0] DK_CONFIG    = 3'd2;
	localparam logic [2:0] DK_STRING    = 3'd3;
	localparam logic [2:0] DK_QUALIFIER = 3'd4;

	// field masks
	localparam logic [7:0] EP_NUM_MASK = 8'h7F;
	localparam logic [7:0] EP_DIR_IN   = 8'h80;

	typedef struct packed {
		logic [4:0] endpoint_count;
		logic [3:0] interface_count;
		logic [7:0] configuration_count;
		logic [7:0] string_count;
		logic [1:0] device_status_bits;
	} cfg_t;

	typedef struct packed {
		logic        func;
		logic [7:0]  setup_attr;
		logic [7:0]  request_code;
		logic [15:0] setup_value;
		logic [15:0] setup_target;
		logic [15:0] setup_length;
	} req_t;

	typedef struct packed {
		logic        accepted;
		logic [1:0]  reply_length;
		logic [7:0]  reply_byte0;
		logic [7:0]  reply_byte1;
		logic [2:0]  descriptor_kind;
		logic [7:0]  descriptor_number;
		logic [15:0] descriptor_limit;
		logic [6:0]  device_address;
		logic [1:0]  device_state_out;
	} rsp_t;

endpackage

[rtl/core/usr_cfg_regs.sv]
`timescale 1ns / 1ps
// usr_cfg_regs: APB-style configuration registers of the request handler.
// Depends on usr_pkg (cfg_t, register indexes, port widths).

module usr_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [usr_pkg::PADDR_W-1:0] paddr,
	input  logic [usr_pkg::PDATA_W-1:0] pwdata,
	output logic [usr_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	output usr_pkg::cfg_t               cfg
);

	usr_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [2:0]    reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.endpoint_count      <= usr_pkg::RST_ENDPOINT_COUNT;
			cfg_q.interface_count     <= '0;
			cfg_q.configuration_count <= '0;
			cfg_q.string_count        <= '0;
			cfg_q.device_status_bits  <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				usr_pkg::REG_ENDPOINT_COUNT:      cfg_q.endpoint_count      <= pwdata[4:0];
				usr_pkg::REG_INTERFACE_COUNT:     cfg_q.interface_count     <= pwdata[3:0];
				usr_pkg::REG_CONFIGURATION_COUNT: cfg_q.configuration_count <= pwdata[7:0];
				usr_pkg::REG_STRING_COUNT:        cfg_q.string_count        <= pwdata[7:0];
				usr_pkg::REG_DEVICE_STATUS_BITS:  cfg_q.device_status_bits  <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			usr_pkg::REG_ENDPOINT_COUNT:
				prdata = {27'd0, cfg_q.endpoint_count};
			usr_pkg::REG_INTERFACE_COUNT:
				prdata = {28'd0, cfg_q.interface_count};
			usr_pkg::REG_CONFIGURATION_COUNT:
				prdata = {24'd0, cfg_q.configuration_count};
			usr_pkg::REG_STRING_COUNT:
				prdata = {24'd0, cfg_q.string_count};
			usr_pkg::REG_DEVICE_STATUS_BITS:
				prdata = {30'd0, cfg_q.device_status_bits};
			default:
				prdata = '0;
		endcase
	end

endmodule

[rtl/core/usr_req_engine.sv]
`timescale 1ns / 1ps
// usr_req_engine: device state registers and the single-pass request decode.
// Depends on usr_pkg (req_t, rsp_t, cfg_t, codes).

module usr_req_engine #(
	parameter int MAX_ENDPOINTS  = usr_pkg::DEF_MAX_ENDPOINTS,
	parameter int MAX_INTERFACES = usr_pkg::DEF_MAX_INTERFACES
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          upd_en,
	input  usr_pkg::req_t req,
	input  usr_pkg::cfg_t cfg,
	output usr_pkg::rsp_t rsp
);

	localparam int EP_IW = (MAX_ENDPOINTS > 1) ? $clog2(MAX_ENDPOINTS) : 1;
	localparam int IF_IW = (MAX_INTERFACES > 1) ? $clog2(MAX_INTERFACES) : 1;
	localparam logic [6:0] EP_LIMIT = 7'(MAX_ENDPOINTS);
	localparam logic [7:0] IF_LIMIT = 8'(MAX_INTERFACES);

	logic [1:0]               state_q, state_d;
	logic [6:0]               addr_q, addr_d;
	logic [7:0]               conf_q, conf_d;
	logic [MAX_ENDPOINTS-1:0] halt_in_q, halt_in_d;
	logic [MAX_ENDPOINTS-1:0] halt_out_q, halt_out_d;
	logic [7:0]               alt_q [MAX_INTERFACES];

	logic             clr_all;
	logic             alt_wr;
	logic [4:0]       rcp;
	logic             dir_in, standard;
	logic [6:0]       ep;
	logic             ep_is_in;
	logic [7:0]       ifc;
	logic [EP_IW-1:0] ep_idx;
	logic [IF_IW-1:0] if_idx;
	logic             ep_ok, if_ok;
	logic [7:0]       dtype, dindex;
	logic             ok;
	logic [1:0]       rlen;
	logic [7:0]       b0;
	logic [2:0]       kind;
	logic             st_ep0, st_epn;
	logic             halt_bit;

	always_comb begin
		rcp      = req.setup_attr[4:0];
		dir_in   = req.setup_attr[7];
		standard = (req.setup_attr[6:5] == 2'd0);
		ep       = req.setup_target[6:0];
		ep_is_in = |(req.setup_target[7:0] & usr_pkg::EP_DIR_IN);
		ifc      = req.setup_target[7:0];
		ep_idx   = ep[EP_IW-1:0];
		if_idx   = ifc[IF_IW-1:0];
		ep_ok    = (ep < {2'd0, cfg.endpoint_count}) && (ep < EP_LIMIT);
		if_ok    = (state_q == usr_pkg::ST_CONFIGURED) &&
		           (ifc < {4'd0, cfg.interface_count}) && (ifc < IF_LIMIT);
		dtype    = req.setup_value[15:8];
		dindex   = req.setup_value[7:0];
		halt_bit = ep_is_in ? halt_in_q[ep_idx] : halt_out_q[ep_idx];
		st_ep0   = (ep == 7'd0) && (state_q != usr_pkg::ST_DEFAULT);
		st_epn   = (ep != 7'd0) && ep_ok && (state_q == usr_pkg::ST_CONFIGURED);

		state_d    = state_q;
		addr_d     = addr_q;
		conf_d     = conf_q;
		halt_in_d  = halt_in_q;
		halt_out_d = halt_out_q;
		clr_all    = 1'b0;
		alt_wr     = 1'b0;
		ok         = 1'b0;
		rlen       = 2'd0;
		b0         = 8'd0;
		kind       = usr_pkg::DK_NONE;

		if (req.func) begin
			clr_all = 1'b1;
			ok      = 1'b1;
			state_d    = usr_pkg::ST_DEFAULT;
			addr_d     = '0;
			conf_d     = '0;
			halt_in_d  = '0;
			halt_out_d = '0;
		end else if (!standard) begin
			ok = 1'b0;
		end else if (req.setup_length == 16'd0) begin
			if (!dir_in) begin
				case (req.request_code)
					usr_pkg::REQ_SET_ADDRESS: begin
						if (state_q != usr_pkg::ST_CONFIGURED && rcp == usr_pkg::RCP_DEVICE) begin
							addr_d  = req.setup_value[6:0];
							state_d = (req.setup_value[6:0] == 7'd0) ?
							          usr_pkg::ST_DEFAULT : usr_pkg::ST_ADDRESS;
							ok = 1'b1;
						end
					end
					usr_pkg::REQ_SET_CONFIG: begin
						if (state_q != usr_pkg::ST_DEFAULT && rcp == usr_pkg::RCP_DEVICE) begin
							conf_d  = req.setup_value[7:0];
							state_d = (req.setup_value[7:0] == 8'd0) ?
							          usr_pkg::ST_ADDRESS : usr_pkg::ST_CONFIGURED;
							ok = 1'b1;
						end
					end
					usr_pkg::REQ_CLEAR_FEATURE, usr_pkg::REQ_SET_FEATURE: begin
						if (rcp == usr_pkg::RCP_EP && ep != 7'd0 && ep_ok &&
						    req.setup_value == 16'd0) begin
							if (ep_is_in)
								halt_in_d[ep_idx] = (req.request_code == usr_pkg::REQ_SET_FEATURE);
							else
								halt_out_d[ep_idx] = (req.request_code == usr_pkg::REQ_SET_FEATURE);
							ok = 1'b1;
						end
					end
					usr_pkg::REQ_SET_INTERFACE: begin
						if (rcp == usr_pkg::RCP_IFACE && if_ok) begin
							alt_wr = 1'b1;
							ok     = 1'b1;
						end
					end
					default: ;
				endcase
			end
		end else if (dir_in) begin
			case (req.request_code)
				usr_pkg::REQ_GET_DESCRIPTOR: begin
					if (rcp == usr_pkg::RCP_DEVICE) begin
						if (dtype == usr_pkg::DT_DEVICE)
							kind = usr_pkg::DK_DEVICE;
						else if (dtype == usr_pkg::DT_CONFIG && dindex < cfg.configuration_count)
							kind = usr_pkg::DK_CONFIG;
						else if (dtype == usr_pkg::DT_STRING && dindex < cfg.string_count)
							kind = usr_pkg::DK_STRING;
						else if (dtype == usr_pkg::DT_QUALIFIER)
							kind = usr_pkg::DK_QUALIFIER;
						ok = (kind != usr_pkg::DK_NONE);
					end
				end
				usr_pkg::REQ_GET_CONFIG: begin
					if (rcp == usr_pkg::RCP_DEVICE && req.setup_value == 16'd0 &&
					    req.setup_target == 16'd0 && req.setup_length == 16'd1 &&
					    state_q != usr_pkg::ST_DEFAULT) begin
						ok   = 1'b1;
						rlen = 2'd1;
						b0   = conf_q;
					end
				end
				usr_pkg::REQ_GET_STATUS: begin
					if (req.setup_value == 16'd0 && req.setup_length == 16'd2) begin
						if (rcp == usr_pkg::RCP_DEVICE) begin
							if (req.setup_target == 16'd0 && state_q != usr_pkg::ST_DEFAULT) begin
								ok = 1'b1;
								b0 = {6'd0, cfg.device_status_bits};
							end
						end else if (rcp == usr_pkg::RCP_IFACE) begin
							ok = if_ok;
						end else if (rcp == usr_pkg::RCP_EP) begin
							if (st_ep0 || st_epn) begin
								ok = 1'b1;
								// endpoint 0 never has its halt bit set
								b0 = {7'd0, st_epn && halt_bit};
							end
						end
						rlen = ok ? 2'd2 : 2'd0;
					end
				end
				usr_pkg::REQ_GET_INTERFACE: begin
					if (req.setup_value == 16'd0 && req.setup_length == 16'd1 &&
					    rcp == usr_pkg::RCP_IFACE && if_ok) begin
						ok   = 1'b1;
						rlen = 2'd1;
						b0   = alt_q[if_idx];
					end
				end
				default: ;
			endcase
		end

		rsp.accepted          = ok;
		rsp.reply_length      = ok ? rlen : 2'd0;
		rsp.reply_byte0       = ok ? b0 : 8'd0;
		rsp.reply_byte1       = 8'd0;
		rsp.descriptor_kind   = ok ? kind : usr_pkg::DK_NONE;
		rsp.descriptor_number = (ok && kind != usr_pkg::DK_NONE) ? dindex : 8'd0;
		rsp.descriptor_limit  = (ok && kind != usr_pkg::DK_NONE) ? req.setup_length : 16'd0;
		rsp.device_address    = addr_d;
		rsp.device_state_out  = state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= usr_pkg::ST_DEFAULT;
			addr_q     <= '0;
			conf_q     <= '0;
			halt_in_q  <= '0;
			halt_out_q <= '0;
		end else if (upd_en) begin
			state_q    <= state_d;
			addr_q     <= addr_d;
			conf_q     <= conf_d;
			halt_in_q  <= halt_in_d;
			halt_out_q <= halt_out_d;
		end
	end

	// alternate settings: one entry written per request, all cleared on bus reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_INTERFACES; i++)
				alt_q[i] <= '0;
		end else if (upd_en && clr_all) begin
			for (int i = 0; i < MAX_INTERFACES; i++)
				alt_q[i] <= '0;
		end else if (upd_en && alt_wr) begin
			alt_q[if_idx] <= req.setup_value[7:0];
		end
	end

	// configured exactly when a non-zero configuration is active
	a_conf_state: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == usr_pkg::ST_CONFIGURED) == (conf_q != 8'd0))
		else $error("configured state and active configuration disagree");

	// default state exactly when no address is held
	a_addr_state: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == usr_pkg::ST_DEFAULT) == (addr_q == 7'd0))
		else $error("default state and bus address disagree");

	// endpoint 0 is never halted through this path
	a_ep0_halt: assert property (@(posedge clk) disable iff (!arst_n)
		!halt_in_q[0] && !halt_out_q[0])
		else $error("control endpoint halt bit set");

	// a stalled request leaves the device state untouched
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_en && !rsp.accepted) |=>
		$stable(state_q) && $stable(addr_q) && $stable(conf_q) &&
		$stable(halt_in_q) && $stable(halt_out_q))
		else $error("stalled request changed device state");

endmodule

[rtl/core/usb_standard_request_handler_top.sv]
`timescale 1ns / 1ps
// usb_standard_request_handler_top: request pipeline, handshake and config port.
// Depends on usr_pkg, usr_cfg_regs and usr_req_engine.

// Chapter 9 standard request handler. Each request (a setup packet, or a bus
// reset when func is high) is taken into an input register, decoded in one
// pass against the device state, and its result is placed in an output
// register; the device state is updated at the same edge, so the following
// request already sees it. One request can be accepted every clock cycle while
// in_stall is low; out_valid rises once the result has passed from the input
// register into the output register, a step held off while out_stall holds
// the output register. in_stall rises only when a request waits in the input
// register and the output register is held by out_stall. Configuration
// registers (endpoint count, interface count, configuration count, string
// count, device status bits) sit at byte addresses 0x00..0x10 and should be
// written only while no request is in flight. No clearing pass follows reset:
// all state is live as soon as reset is released.

module usb_standard_request_handler_top #(
	parameter int MAX_ENDPOINTS  = usr_pkg::DEF_MAX_ENDPOINTS,
	parameter int MAX_INTERFACES = usr_pkg::DEF_MAX_INTERFACES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// request channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        func,
	input  logic [7:0]                  setup_attr,
	input  logic [7:0]                  request_code,
	input  logic [15:0]                 setup_value,
	input  logic [15:0]                 setup_target,
	input  logic [15:0]                 setup_length,
	// result channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        accepted,
	output logic [1:0]                  reply_length,
	output logic [7:0]                  reply_byte0,
	output logic [7:0]                  reply_byte1,
	output logic [2:0]                  descriptor_kind,
	output logic [7:0]                  descriptor_number,
	output logic [15:0]                 descriptor_limit,
	output logic [6:0]                  device_address,
	output logic [1:0]                  device_state_out,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [usr_pkg::PADDR_W-1:0] paddr,
	input  logic [usr_pkg::PDATA_W-1:0] pwdata,
	output logic [usr_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);

	usr_pkg::cfg_t cfg;
	usr_pkg::req_t req_s1;
	usr_pkg::rsp_t rsp_comb;
	usr_pkg::rsp_t rsp_s2;
	logic          vld_s1, vld_s2;
	logic          out_free;   // output register can take a result
	logic          in_fire;    // request accepted into stage 1
	logic          dec_fire;   // stage 1 request decoded and committed

	usr_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	usr_req_engine #(
		.MAX_ENDPOINTS  (MAX_ENDPOINTS),
		.MAX_INTERFACES (MAX_INTERFACES)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.upd_en (dec_fire),
		.req    (req_s1),
		.cfg    (cfg),
		.rsp    (rsp_comb)
	);

	assign out_free = !vld_s2 || !out_stall;
	assign dec_fire = vld_s1 && out_free;
	assign in_stall = vld_s1 && !out_free;
	assign in_fire  = in_valid && !in_stall;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_fire || (vld_s1 && !out_free);
			vld_s2 <= dec_fire || (vld_s2 && out_stall);
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_s1.func         <= func;
			req_s1.setup_attr   <= setup_attr;
			req_s1.request_code <= request_code;
			req_s1.setup_value  <= setup_value;
			req_s1.setup_target <= setup_target;
			req_s1.setup_length <= setup_length;
		end
		if (dec_fire)
			rsp_s2 <= rsp_comb;
	end

	assign out_valid         = vld_s2;
	assign accepted          = rsp_s2.accepted;
	assign reply_length      = rsp_s2.reply_length;
	assign reply_byte0       = rsp_s2.reply_byte0;
	assign reply_byte1       = rsp_s2.reply_byte1;
	assign descriptor_kind   = rsp_s2.descriptor_kind;
	assign descriptor_number = rsp_s2.descriptor_number;
	assign descriptor_limit  = rsp_s2.descriptor_limit;
	assign device_address    = rsp_s2.device_address;
	assign device_state_out  = rsp_s2.device_state_out;

endmodule

[dv/usb_standard_request_handler_top_tb.sv]
`timescale 1ns / 1ps
// usb_standard_request_handler_top_tb: self-checking bench for the chapter 9 request handler.
// Depends on usr_pkg and usb_standard_request_handler_top; holds its own decoder and device state.

module usb_standard_request_handler_top_tb;

	localparam int MAX_EP = usr_pkg::DEF_MAX_ENDPOINTS;
	localparam int MAX_IF = usr_pkg::DEF_MAX_INTERFACES;

	// generous ceiling: ~1700 requests, each worst case a long gap plus heavy back-pressure
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES = 8;
	localparam int REQUESTS_PER_PHASE = 210;

	// bmRequestType values used by the stimulus
	localparam logic [7:0] RT_OUT_DEVICE  = {3'b000, usr_pkg::RCP_DEVICE};
	localparam logic [7:0] RT_OUT_IFACE   = {3'b000, usr_pkg::RCP_IFACE};
	localparam logic [7:0] RT_OUT_EP      = {3'b000, usr_pkg::RCP_EP};
	localparam logic [7:0] RT_IN_DEVICE   = {3'b100, usr_pkg::RCP_DEVICE};
	localparam logic [7:0] RT_IN_IFACE    = {3'b100, usr_pkg::RCP_IFACE};
	localparam logic [7:0] RT_IN_EP       = {3'b100, usr_pkg::RCP_EP};
	localparam logic [7:0] RT_CLASS_IFACE = 8'h21;
	localparam logic [7:0] RT_VENDOR_IN   = 8'hC0;

	localparam logic [7:0]  REQ_UNKNOWN        = 8'hFF;
	localparam logic [15:0] FEAT_ENDPOINT_HALT = 16'd0;
	localparam logic [15:0] FEAT_REMOTE_WAKEUP = 16'd1;

	// back-pressure patterns on the result side
	typedef enum logic [1:0] {HOLD_NONE, HOLD_LIGHT, HOLD_HEAVY, HOLD_PERIODIC} hold_mode_t;

	// Device model plus the queue of answers still owed by the block.
	class ch9_answer_check;
		logic [4:0]    ep_count;
		logic [3:0]    if_count;
		logic [7:0]    cfg_count;
		logic [7:0]    str_count;
		logic [1:0]    status_bits;
		logic [1:0]    dev_state;
		logic [6:0]    bus_addr;
		logic [7:0]    cur_config;
		logic [15:0]   halt_in;
		logic [15:0]   halt_out;
		logic [7:0]    alt_setting [MAX_IF];
		usr_pkg::rsp_t answers_due [$];
		int            mismatches;

		function new();
			ep_count = usr_pkg::RST_ENDPOINT_COUNT;
			if_count = '0;
			cfg_count = '0;
			str_count = '0;
			status_bits = '0;
			mismatches = 0;
			clear_device();
		endfunction

		function void clear_device();
			dev_state = usr_pkg::ST_DEFAULT;
			bus_addr = '0;
			cur_config = '0;
			halt_in = '0;
			halt_out = '0;
			foreach (alt_setting[i])
				alt_setting[i] = '0;
		endfunction

		function void set_register(logic [2:0] idx, logic [31:0] data);
			case (idx)
			usr_pkg::REG_ENDPOINT_COUNT:      ep_count = data[4:0];
			usr_pkg::REG_INTERFACE_COUNT:     if_count = data[3:0];
			usr_pkg::REG_CONFIGURATION_COUNT: cfg_count = data[7:0];
			usr_pkg::REG_STRING_COUNT:        str_count = data[7:0];
			usr_pkg::REG_DEVICE_STATUS_BITS:  status_bits = data[1:0];
			default: ;
			endcase
		endfunction

		function logic ep_valid(logic [6:0] ep);
			return ep < ep_count && ep < MAX_EP;
		endfunction

		function logic iface_valid(logic [7:0] ifc);
			return dev_state == usr_pkg::ST_CONFIGURED && ifc < if_count && ifc < MAX_IF;
		endfunction

		// Works out the answer to one request and moves the device state on.
		function usr_pkg::rsp_t decode_setup(usr_pkg::req_t r);
			usr_pkg::rsp_t o;
			logic        ok;
			logic        dir_in;
			logic        std_type;
			logic        ep_in;
			logic [4:0]  rcp;
			logic [6:0]  ep;
			logic [7:0]  ifc;
			logic [7:0]  dtype;
			logic [7:0]  dindex;
			logic [2:0]  kind;
			logic [15:0] hmask;
			o = '0;
			ok = 1'b0;
			rcp = r.setup_attr[4:0];
			dir_in = r.setup_attr[7];
			std_type = r.setup_attr[6:5] == 2'b00;
			ep = r.setup_target[6:0];
			ep_in = r.setup_target[7];
			ifc = r.setup_target[7:0];
			if (r.func) begin
				clear_device();
				ok = 1'b1;
			end else if (!std_type) begin
				ok = 1'b0;
			end else if (r.setup_length == 16'd0) begin
				if (!dir_in) begin
					case (r.request_code)
					usr_pkg::REQ_SET_ADDRESS: begin
						if (dev_state != usr_pkg::ST_CONFIGURED && rcp == usr_pkg::RCP_DEVICE) begin
							bus_addr = r.setup_value[6:0];
							dev_state = (bus_addr == 7'd0) ? usr_pkg::ST_DEFAULT
								: usr_pkg::ST_ADDRESS;
							ok = 1'b1;
						end
					end
					usr_pkg::REQ_SET_CONFIG: begin
						if (dev_state != usr_pkg::ST_DEFAULT && rcp == usr_pkg::RCP_DEVICE) begin
							cur_config = r.setup_value[7:0];
							dev_state = (cur_config == 8'd0) ? usr_pkg::ST_ADDRESS
								: usr_pkg::ST_CONFIGURED;
							ok = 1'b1;
						end
					end
					usr_pkg::REQ_CLEAR_FEATURE, usr_pkg::REQ_SET_FEATURE: begin
						if (rcp == usr_pkg::RCP_EP && ep >= 7'd1 && ep_valid(ep) &&
						    r.setup_value == FEAT_ENDPOINT_HALT) begin
							if (ep_in)
								halt_in[ep[3:0]] = (r.request_code == usr_pkg::REQ_SET_FEATURE);
							else
								halt_out[ep[3:0]] = (r.request_code == usr_pkg::REQ_SET_FEATURE);
							ok = 1'b1;
						end
					end
					usr_pkg::REQ_SET_INTERFACE: begin
						if (rcp == usr_pkg::RCP_IFACE && iface_valid(ifc)) begin
							alt_setting[ifc[2:0]] = r.setup_value[7:0];
							ok = 1'b1;
						end
					end
					default: ;
					endcase
				end
			end else if (dir_in) begin
				case (r.request_code)
				usr_pkg::REQ_GET_DESCRIPTOR: begin
					if (rcp == usr_pkg::RCP_DEVICE) begin
						dtype = r.setup_value[15:8];
						dindex = r.setup_value[7:0];
						kind = usr_pkg::DK_NONE;
						if (dtype == usr_pkg::DT_DEVICE)
							kind = usr_pkg::DK_DEVICE;
						else if (dtype == usr_pkg::DT_CONFIG && dindex < cfg_count)
							kind = usr_pkg::DK_CONFIG;
						else if (dtype == usr_pkg::DT_STRING && dindex < str_count)
							kind = usr_pkg::DK_STRING;
						else if (dtype == usr_pkg::DT_QUALIFIER)
							kind = usr_pkg::DK_QUALIFIER;
						if (kind != usr_pkg::DK_NONE) begin
							ok = 1'b1;
							o.descriptor_kind = kind;
							o.descriptor_number = dindex;
							o.descriptor_limit = r.setup_length;
						end
					end
				end
				usr_pkg::REQ_GET_CONFIG: begin
					if (rcp == usr_pkg::RCP_DEVICE && r.setup_value == 16'd0 &&
					    r.setup_target == 16'd0 && r.setup_length == 16'd1 &&
					    dev_state != usr_pkg::ST_DEFAULT) begin
						ok = 1'b1;
						o.reply_length = 2'd1;
						o.reply_byte0 = cur_config;
					end
				end
				usr_pkg::REQ_GET_STATUS: begin
					if (r.setup_value == 16'd0 && r.setup_length == 16'd2) begin
						if (rcp == usr_pkg::RCP_DEVICE) begin
							if (r.setup_target == 16'd0 && dev_state != usr_pkg::ST_DEFAULT) begin
								ok = 1'b1;
								o.reply_byte0 = {6'd0, status_bits};
							end
						end else if (rcp == usr_pkg::RCP_IFACE) begin
							ok = iface_valid(ifc);
						end else if (rcp == usr_pkg::RCP_EP) begin
							if ((ep == 7'd0 && dev_state != usr_pkg::ST_DEFAULT) ||
							    (ep >= 7'd1 && ep_valid(ep) &&
							     dev_state == usr_pkg::ST_CONFIGURED)) begin
								hmask = ep_in ? halt_in : halt_out;
								ok = 1'b1;
								o.reply_byte0 = {7'd0, hmask[ep[3:0]]};
							end
						end
						if (ok)
							o.reply_length = 2'd2;
					end
				end
				usr_pkg::REQ_GET_INTERFACE: begin
					if (r.setup_value == 16'd0 && r.setup_length == 16'd1 &&
					    rcp == usr_pkg::RCP_IFACE && iface_valid(ifc)) begin
						ok = 1'b1;
						o.reply_length = 2'd1;
						o.reply_byte0 = alt_setting[ifc[2:0]];
					end
				end
				default: ;
				endcase
			end
			if (!ok)
				o = '0;
			o.accepted = ok;
			o.device_address = bus_addr;
			o.device_state_out = dev_state;
			return o;
		endfunction

		function void note_request(usr_pkg::req_t r);
			answers_due.push_back(decode_setup(r));
		endfunction

		function string show(usr_pkg::rsp_t a);
			return $sformatf("acc=%0d len=%0d b0=%h b1=%h kind=%0d num=%h lim=%h addr=%h st=%0d",
				a.accepted, a.reply_length, a.reply_byte0, a.reply_byte1, a.descriptor_kind,
				a.descriptor_number, a.descriptor_limit, a.device_address, a.device_state_out);
		endfunction

		function void check_result(usr_pkg::rsp_t got);
			usr_pkg::rsp_t want;
			string bad;
			if (answers_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] result with nothing outstanding: %s", $realtime, show(got));
				return;
			end
			want = answers_due.pop_front();
			bad = "";
			if (got.accepted !== want.accepted)                 bad = {bad, " accepted"};
			if (got.reply_length !== want.reply_length)         bad = {bad, " reply_length"};
			if (got.reply_byte0 !== want.reply_byte0)           bad = {bad, " reply_byte0"};
			if (got.reply_byte1 !== want.reply_byte1)           bad = {bad, " reply_byte1"};
			if (got.descriptor_kind !== want.descriptor_kind)   bad = {bad, " descriptor_kind"};
			if (got.descriptor_number !== want.descriptor_number)
				bad = {bad, " descriptor_number"};
			if (got.descriptor_limit !== want.descriptor_limit) bad = {bad, " descriptor_limit"};
			if (got.device_address !== want.device_address)     bad = {bad, " device_address"};
			if (got.device_state_out !== want.device_state_out) bad = {bad, " device_state_out"};
			if (bad != "") begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] mismatch in%s\n  want %s\n  got  %s",
						$realtime, bad, show(want), show(got));
			end
		endfunction
	endclass

	// ---------------------------------------------------------------------
	// DUT connections; every input starts at a known level
	// ---------------------------------------------------------------------
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        func = 1'b0;
	logic [7:0]  setup_attr = '0;
	logic [7:0]  request_code = '0;
	logic [15:0] setup_value = '0;
	logic [15:0] setup_target = '0;
	logic [15:0] setup_length = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        accepted;
	logic [1:0]  reply_length;
	logic [7:0]  reply_byte0;
	logic [7:0]  reply_byte1;
	logic [2:0]  descriptor_kind;
	logic [7:0]  descriptor_number;
	logic [15:0] descriptor_limit;
	logic [6:0]  device_address;
	logic [1:0]  device_state_out;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [usr_pkg::PADDR_W-1:0] paddr = '0;
	logic [usr_pkg::PDATA_W-1:0] pwdata = '0;
	logic [usr_pkg::PDATA_W-1:0] prdata;
	logic        pready;

	ch9_answer_check answers;
	int          cycles = 0;
	int          burst_left = 0;
	hold_mode_t  hold_mode = HOLD_NONE;
	int          hold_left = 0;

	usb_standard_request_handler_top u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.func              (func),
		.setup_attr        (setup_attr),
		.request_code      (request_code),
		.setup_value       (setup_value),
		.setup_target      (setup_target),
		.setup_length      (setup_length),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.accepted          (accepted),
		.reply_length      (reply_length),
		.reply_byte0       (reply_byte0),
		.reply_byte1       (reply_byte1),
		.descriptor_kind   (descriptor_kind),
		.descriptor_number (descriptor_number),
		.descriptor_limit  (descriptor_limit),
		.device_address    (device_address),
		.device_state_out  (device_state_out),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// watchdog: a hung handshake or a lost result ends here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("usb_standard_request_handler_top_tb NOT OK");
			$finish;
		end
	end

	// Result side back-pressure: the pattern is redrawn each time its random hold count runs out, between
	// no stall at all, light and heavy random stall, and a fixed duty cycle.
	always @(posedge clk) begin
		if (hold_left == 0) begin
			hold_mode <= hold_mode_t'($urandom_range(0, 3));
			hold_left <= $urandom_range(50, 400);
		end else begin
			hold_left <= hold_left - 1;
		end
		case (hold_mode)
		HOLD_NONE:  out_stall <= 1'b0;
		HOLD_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
		HOLD_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
		default:    out_stall <= (cycles % 7) < 3;
		endcase
	end

	// Result monitor: values sampled at the edge are the pre-edge ones, so this
	// sees exactly what the handshake moved.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			answers.check_result({accepted, reply_length, reply_byte0, reply_byte1,
				descriptor_kind, descriptor_number, descriptor_limit,
				device_address, device_state_out});
	end

	// ---------------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------------

	// Two-phase APB write; the register takes the value at the access edge.
	task automatic apb_write(input logic [2:0] idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		answers.set_register(idx, data);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic configure(input logic [4:0] epc, input logic [3:0] ifc,
			input logic [7:0] cfgc, input logic [7:0] strc, input logic [1:0] stb);
		apb_write(usr_pkg::REG_ENDPOINT_COUNT, {27'd0, epc});
		apb_write(usr_pkg::REG_INTERFACE_COUNT, {28'd0, ifc});
		apb_write(usr_pkg::REG_CONFIGURATION_COUNT, {24'd0, cfgc});
		apb_write(usr_pkg::REG_STRING_COUNT, {24'd0, strc});
		apb_write(usr_pkg::REG_DEVICE_STATUS_BITS, {30'd0, stb});
	endtask

	// Presents one request and returns at the edge that takes it. The sender runs in
	// bursts; valid only drops between bursts, so it is never lowered and raised in
	// one step. The expectation is formed at acceptance, in acceptance order.
	task automatic send_request(input usr_pkg::req_t r);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 10);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
				: $urandom_range(1, 12);
		end
		func <= r.func;
		setup_attr <= r.setup_attr;
		request_code <= r.request_code;
		setup_value <= r.setup_value;
		setup_target <= r.setup_target;
		setup_length <= r.setup_length;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		answers.note_request(r);
		burst_left--;
	endtask

	// Stop sending and wait until every answer owed has come back, then let the
	// clock run on idle before the registers are touched.
	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (answers.answers_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic usr_pkg::req_t setup_packet(input logic f, input logic [7:0] rt,
			input logic [7:0] code, input logic [15:0] val, input logic [15:0] idx,
			input logic [15:0] len);
		usr_pkg::req_t r;
		r.func = f;
		r.setup_attr = rt;
		r.request_code = code;
		r.setup_value = val;
		r.setup_target = idx;
		r.setup_length = len;
		return r;
	endfunction

	// endpoint wIndex: random direction, numbers up to one past the last valid one
	function automatic logic [15:0] random_ep_index();
		return {8'h00, 1'($urandom_range(0, 1)), 7'($urandom_range(0, answers.ep_count))};
	endfunction

	// Mostly well-formed standard requests with random content, steered towards the
	// next enumeration step so the configured state is reached often; the rest is
	// bus resets, raw noise and requests with one bit flipped.
	function automatic usr_pkg::req_t draw_request();
		usr_pkg::req_t r;
		int         roll;
		int         pick;
		logic [4:0] rc;
		logic [7:0] dtype;
		logic [7:0] dindex;
		roll = $urandom_range(0, 99);
		r.func = 1'b0;
		r.setup_attr = 8'($urandom_range(0, 255));
		r.request_code = 8'($urandom_range(0, 255));
		r.setup_value = 16'($urandom_range(0, 65535));
		r.setup_target = 16'($urandom_range(0, 65535));
		r.setup_length = 16'($urandom_range(0, 65535));
		if (roll < 4) begin
			r.func = 1'b1;
			return r;
		end
		if (roll < 12)
			return r;
		pick = $urandom_range(0, 8);
		if (answers.dev_state == usr_pkg::ST_DEFAULT && roll < 40)
			pick = 0;
		else if (answers.dev_state == usr_pkg::ST_ADDRESS && roll < 40)
			pick = 1;
		r.setup_value = 16'd0;
		r.setup_target = 16'd0;
		r.setup_length = 16'd0;
		case (pick)
		0: begin
			r.setup_attr = RT_OUT_DEVICE;
			r.request_code = usr_pkg::REQ_SET_ADDRESS;
			r.setup_value = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
				: 16'($urandom_range(0, 127));
		end
		1: begin
			r.setup_attr = RT_OUT_DEVICE;
			r.request_code = usr_pkg::REQ_SET_CONFIG;
			r.setup_value = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
				: 16'($urandom_range(0, 3));
		end
		3: begin
			r.setup_attr = RT_OUT_IFACE;
			r.request_code = usr_pkg::REQ_SET_INTERFACE;
			r.setup_value = 16'($urandom_range(0, 255));
			r.setup_target = 16'($urandom_range(0, answers.if_count));
		end
		4: begin
			rc = 5'($urandom_range(0, 2));
			r.setup_attr = {3'b100, rc};
			r.request_code = usr_pkg::REQ_GET_STATUS;
			r.setup_length = 16'd2;
			if (rc == usr_pkg::RCP_IFACE)
				r.setup_target = 16'($urandom_range(0, answers.if_count));
			else if (rc == usr_pkg::RCP_EP)
				r.setup_target = random_ep_index();
		end
		5: begin
			r.setup_attr = RT_IN_DEVICE;
			r.request_code = usr_pkg::REQ_GET_CONFIG;
			r.setup_length = 16'd1;
		end
		6: begin
			r.setup_attr = RT_IN_IFACE;
			r.request_code = usr_pkg::REQ_GET_INTERFACE;
			r.setup_target = 16'($urandom_range(0, answers.if_count));
			r.setup_length = 16'd1;
		end
		7: begin
			case ($urandom_range(0, 4))
			0:       dtype = usr_pkg::DT_DEVICE;
			1:       dtype = usr_pkg::DT_CONFIG;
			2:       dtype = usr_pkg::DT_STRING;
			3:       dtype = usr_pkg::DT_QUALIFIER;
			default: dtype = 8'($urandom_range(0, 255));
			endcase
			dindex = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(0, 4));
			r.setup_attr = RT_IN_DEVICE;
			r.request_code = usr_pkg::REQ_GET_DESCRIPTOR;
			r.setup_value = {dtype, dindex};
			r.setup_length = 16'($urandom_range(1, 65535));
		end
		default: begin
			// halt feature, set or clear
			r.setup_attr = RT_OUT_EP;
			r.request_code = $urandom_range(0, 1) ? usr_pkg::REQ_SET_FEATURE
				: usr_pkg::REQ_CLEAR_FEATURE;
			r.setup_value = FEAT_ENDPOINT_HALT;
			r.setup_target = random_ep_index();
		end
		endcase
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 4))
			0:       r.setup_attr = r.setup_attr ^ (8'd1 << $urandom_range(0, 7));
			1:       r.request_code = r.request_code ^ (8'd1 << $urandom_range(0, 7));
			2:       r.setup_value = r.setup_value ^ (16'd1 << $urandom_range(0, 15));
			3:       r.setup_target = r.setup_target ^ (16'd1 << $urandom_range(0, 15));
			default: r.setup_length = r.setup_length ^ (16'd1 << $urandom_range(0, 15));
			endcase
		end
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------------
	initial begin
		answers = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: 4 endpoints, 3 interfaces, 2 configurations, 3 strings, both status bits
		configure(5'd4, 4'd3, 8'd2, 8'd3, 2'd3);
		// bus reset with every other field at its top value
		send_request(setup_packet(1'b1, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		// device status is refused in the default state
		send_request(setup_packet(1'b0, RT_IN_DEVICE, usr_pkg::REQ_GET_STATUS,
			16'd0, 16'd0, 16'd2));
		send_request(setup_packet(1'b0, RT_IN_DEVICE, usr_pkg::REQ_GET_DESCRIPTOR,
			{usr_pkg::DT_DEVICE, 8'h00}, 16'd0, 16'hFFFF));
		send_request(setup_packet(1'b0, RT_IN_DEVICE, usr_pkg::REQ_GET_DESCRIPTOR,
			{usr_pkg::DT_QUALIFIER, 8'hFF}, 16'd0, 16'd1));
		// configuration index at the count is out of range
		send_request(setup_packet(1'b0, RT_IN_DEVICE, usr_pkg::REQ_GET_DESCRIPTOR,
			{usr_pkg::DT_CONFIG, 8'd2}, 16'd0, 16'd9));
		send_request(setup_packet(1'b0, RT_IN_DEVICE, usr_pkg::REQ_GET_DESCRIPTOR,
			{usr_pkg::DT_STRING, 8'd2}, 16'h0409, 16'd255));
		// descriptor request addressed to an interface stalls
		send_request(setup_packet(1'b0, RT_IN_IFACE, usr_pkg::REQ_GET_DESCRIPTOR,
			{usr_pkg::DT_DEVICE, 8'h00}, 16'd0, 16'd18));
		// wide address: only the low seven bits count
		send_request(setup_packet(1'b0, RT_OUT_DEVICE, usr_pkg::REQ_SET_ADDRESS,
			16'hFFFF, 16'd0, 16'd0));
		send_request(setup_packet(1'b0, RT_IN_DEVICE, usr_pkg::REQ_GET_STATUS,
			16'd0, 16'd0, 16'd2));
		// endpoint 0 status allowed in the address state, endpoint 1 is not
		send_request(setup_packet(1'b0, RT_IN_EP, usr_pkg::REQ_GET_STATUS,
			16'd0, 16'h0080, 16'd2));
		send_request(setup_packet(1'b0, RT_IN_EP, usr_pkg::REQ_GET_STATUS,
			16'd0, 16'h0001, 16'd2));
		send_request(setup_packet(1'b0, RT_IN_DEVICE, usr_pkg::REQ_GET_CONFIG,
			16'd0, 16'd0, 16'd1));
		// wide configuration: only the low byte counts
		send_request(setup_packet(1'b0, RT_OUT_DEVICE, usr_pkg::REQ_SET_CONFIG,
			16'h01FF, 16'd0, 16'd0));
		send_request(setup_packet(1'b0, RT_OUT_EP, usr_pkg::REQ_SET_FEATURE,
			FEAT_ENDPOINT_HALT, 16'h0081, 16'd0));
		// upper wIndex bits are ignored for the endpoint number
		send_request(setup_packet(1'b0, RT_OUT_EP, usr_pkg::REQ_SET_FEATURE,
			FEAT_ENDPOINT_HALT, 16'hFF03, 16'd0));
		send_request(setup_packet(1'b0, RT_OUT_EP, usr_pkg::REQ_SET_FEATURE,
			FEAT_ENDPOINT_HALT, 16'h0004, 16'd0));
		// device feature (remote wakeup) is not supported
		send_request(setup_packet(1'b0, RT_OUT_DEVICE, usr_pkg::REQ_SET_FEATURE,
			FEAT_REMOTE_WAKEUP, 16'd0, 16'd0));
		send_request(setup_packet(1'b0, RT_IN_EP, usr_pkg::REQ_GET_STATUS,
			16'd0, 16'h0003, 16'd2));
		send_request(setup_packet(1'b0, RT_OUT_EP, usr_pkg::REQ_CLEAR_FEATURE,
			FEAT_ENDPOINT_HALT, 16'h0081, 16'd0));
		send_request(setup_packet(1'b0, RT_IN_EP, usr_pkg::REQ_GET_STATUS,
			16'd0, 16'h0081, 16'd2));
		send_request(setup_packet(1'b0, RT_OUT_IFACE, usr_pkg::REQ_SET_INTERFACE,
			16'h00AB, 16'd2, 16'd0));
		send_request(setup_packet(1'b0, RT_IN_IFACE, usr_pkg::REQ_GET_INTERFACE,
			16'd0, 16'd2, 16'd1));
		// interface number at the count stalls
		send_request(setup_packet(1'b0, RT_OUT_IFACE, usr_pkg::REQ_SET_INTERFACE,
			16'd1, 16'd3, 16'd0));
		send_request(setup_packet(1'b0, RT_IN_IFACE, usr_pkg::REQ_GET_STATUS,
			16'd0, 16'd0, 16'd2));
		// class and vendor types, and an unknown code, all stall
		send_request(setup_packet(1'b0, RT_CLASS_IFACE, usr_pkg::REQ_SET_INTERFACE,
			16'd0, 16'd0, 16'd0));
		send_request(setup_packet(1'b0, RT_VENDOR_IN, usr_pkg::REQ_GET_STATUS,
			16'd0, 16'd0, 16'd2));
		send_request(setup_packet(1'b0, RT_IN_DEVICE, REQ_UNKNOWN, 16'd0, 16'd0, 16'd2));

		// random phases: top settings, bottom settings, then random ones
		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			if (phase == 0)
				configure(5'd16, 4'd8, 8'd255, 8'd255, 2'd3);
			else if (phase == 1)
				configure(5'd1, 4'd0, 8'd0, 8'd0, 2'd0);
			else
				configure(5'($urandom_range(1, 16)), 4'($urandom_range(0, 8)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					2'($urandom_range(0, 3)));
			repeat (REQUESTS_PER_PHASE)
				send_request(draw_request());
		end

		settle();
		repeat (8) @(posedge clk);
		if (answers.mismatches == 0)
			$display("usb_standard_request_handler_top_tb OK");
		else
			$display("usb_standard_request_handler_top_tb NOT OK");
		$finish;
	end

endmodule

[sim.f]
rtl/core/usr_pkg.sv
rtl/core/usr_cfg_regs.sv
rtl/core/usr_req_engine.sv
rtl/core/usb_standard_request_handler_top.sv
dv/usb_standard_request_handler_top_tb.sv
